FILE: rtl/core/frb_pkg.sv
// ----------------------------------------------------------------------------
// frb_pkg: shared types and constants for the frame ring buffer
// Field widths, result status codes and controller/datapath handoff structs.
// ----------------------------------------------------------------------------
package frb_pkg;

  // Field widths
  localparam int ID_W    = 32;
  localparam int TIME_W  = 32;
  localparam int BATCH_W = 6;

  // Default ring depth (power of two, 2..1024)
  localparam int DEPTH_DEF = 32;

  // Largest burst one play may remove
  localparam int MAX_BURST = 32;

  // Batch size after reset
  localparam logic [BATCH_W-1:0] BATCH_RESET = 6'd5;

  // Request kinds
  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_PLAY = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ADDED  = 2'd0,
    ST_FULL   = 2'd1,
    ST_WAIT   = 2'd2,
    ST_PLAYED = 2'd3
  } frb_status_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic add;    // store an added frame, answer added or full
    logic defer;  // answer wait on a play
    logic start;  // load the burst counter for a play
    logic pop;    // read one frame from the head into the output
  } frb_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic slot_free;  // output register empty or emptying this cycle
    logic enough;     // ring holds at least one batch
    logic burst_end;  // next pop is the final one of the burst
  } frb_stat_t;

endpackage

FILE: rtl/core/frb_ifs.sv
// ----------------------------------------------------------------------------
// frb_ifs: channel interfaces of the frame ring buffer
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------

// Request channel: add a frame or play a batch
interface frb_req_if;
  import frb_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [ID_W-1:0]   frame_id;
  logic        [TIME_W-1:0] frame_time;

  modport source (output valid, output kind, output frame_id, output frame_time,
                  input ready);
  modport sink   (input valid, input kind, input frame_id, input frame_time,
                  output ready);
endinterface

// Result channel: one beat per result
interface frb_rsp_if;
  import frb_pkg::*;
  logic                     valid;
  logic                     ready;
  logic        [1:0]        status;
  logic signed [ID_W-1:0]   out_id;
  logic        [TIME_W-1:0] out_time;
  logic                     last;

  modport source (output valid, output status, output out_id, output out_time,
                  output last, input ready);
  modport sink   (input valid, input status, input out_id, input out_time,
                  input last, output ready);
endinterface

// Configuration channel: batch size write
interface frb_cfg_if;
  import frb_pkg::*;
  logic               valid;
  logic               ready;
  logic [BATCH_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/frame_ring_buffer_batch_play.sv
// ----------------------------------------------------------------------------
// frame_ring_buffer_batch_play: circular frame FIFO with burst read
// Stores frames at the tail and plays them out in batches from the head.
// ----------------------------------------------------------------------------
// Usage:
//   req : request beats. kind add stores frame_id/frame_time and answers one
//         beat, added or full (frame dropped). kind play answers one wait beat
//         when fewer than a batch are held, else one played beat per frame,
//         oldest first, with last set on the final one.
//   rsp : result beats; out_id/out_time are zero except on played frames.
//   cfg : batch size write (0 acts as 1, above 32 acts as 32); write only
//         while the block is idle. Always ready.
// Timing: a request is taken when the output register is empty or being
//   emptied. Add and wait answer on the next cycle, one request per cycle
//   while the receiver keeps up. A play first loads the burst counter, then
//   the single-port head read delivers one frame per cycle while the
//   receiver keeps up. No request is taken during a burst. When the
//   receiver stalls the output beat holds and the burst pauses. Reset
//   empties the ring and sets the batch size to 5; the store itself is
//   not cleared.
// ----------------------------------------------------------------------------
module frame_ring_buffer_batch_play #(
  parameter int DEPTH = frb_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  frb_req_if.sink   req,
  frb_rsp_if.source rsp,
  frb_cfg_if.sink   cfg
);
  import frb_pkg::*;

  frb_cmd_t  cmd;
  frb_stat_t stat;
  logic      ctrl_ready;

  assign req.ready = ctrl_ready;

  frb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .kind     (req.kind),
    .in_ready (ctrl_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  frb_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .frame_id   (req.frame_id),
    .frame_time (req.frame_time),
    .cfg        (cfg),
    .rsp        (rsp)
  );

  // Commands never overlap
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.add, cmd.defer, cmd.start, cmd.pop}))
    else $error("overlapping datapath commands");

  // Requests are taken only when the output slot frees
  assert property (@(posedge clk) disable iff (rst)
    req.ready |-> (!rsp.valid || rsp.ready))
    else $error("request taken while result beat blocked");

  // Final pop of a burst shows up as a played beat with last set
  assert property (@(posedge clk) disable iff (rst)
    cmd.pop && stat.burst_end |=> rsp.valid && rsp.last && rsp.status == ST_PLAYED)
    else $error("burst end not marked last");

  // A started burst is followed by a pop-only phase, no new request
  assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !req.ready)
    else $error("request accepted during a burst");

endmodule

FILE: rtl/core/frb_datapath.sv
// ----------------------------------------------------------------------------
// frb_datapath: frame storage, pointers and result register
// Holds the frame ring, head/tail/fill state, batch size and the output beat.
// ----------------------------------------------------------------------------
module frb_datapath #(
  parameter int DEPTH = frb_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  frb_pkg::frb_cmd_t                cmd,
  output frb_pkg::frb_stat_t               stat,
  input  logic signed [frb_pkg::ID_W-1:0]  frame_id,
  input  logic [frb_pkg::TIME_W-1:0]       frame_time,
  frb_cfg_if.sink                          cfg,
  frb_rsp_if.source                        rsp
);
  import frb_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (CW > BATCH_W) ? CW : BATCH_W;

  // Ring storage
  logic [ID_W-1:0]   id_mem   [DEPTH];
  logic [TIME_W-1:0] time_mem [DEPTH];

  // Control state
  logic [AW-1:0]      head;
  logic [AW-1:0]      tail;
  logic [CW-1:0]      fill;
  logic [BATCH_W-1:0] batch;
  logic [BATCH_W-1:0] remain;
  logic               o_valid;

  // Output payload
  frb_status_t       o_status;
  logic              o_last;
  logic [ID_W-1:0]   rd_id;
  logic [TIME_W-1:0] rd_time;

  logic [BATCH_W-1:0] n_eff;
  logic               full;
  logic               wr_en;

  // Clamp batch size to 1..MAX_BURST
  always_comb begin
    if (batch == '0) begin
      n_eff = BATCH_W'(1);
    end else if (batch > BATCH_W'(MAX_BURST)) begin
      n_eff = BATCH_W'(MAX_BURST);
    end else begin
      n_eff = batch;
    end
  end

  assign full  = (fill == CW'(DEPTH));
  assign wr_en = cmd.add && !full;

  assign stat.slot_free = !o_valid || rsp.ready;
  assign stat.enough    = (CMP_W'(fill) >= CMP_W'(n_eff));
  assign stat.burst_end = (remain == BATCH_W'(1));

  // Configuration is always taken
  assign cfg.ready = 1'b1;

  // Result beat: zero payload except on played frames
  assign rsp.valid    = o_valid;
  assign rsp.status   = o_status;
  assign rsp.last     = o_last;
  assign rsp.out_id   = (o_status == ST_PLAYED) ? rd_id   : '0;
  assign rsp.out_time = (o_status == ST_PLAYED) ? rd_time : '0;

  // Write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[tail]   <= frame_id;
      time_mem[tail] <= frame_time;
    end
    if (cmd.pop) begin
      rd_id   <= id_mem[head];
      rd_time <= time_mem[head];
    end
  end

  // Pointers, fill count, batch size and burst counter
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      fill   <= '0;
      batch  <= BATCH_RESET;
      remain <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        batch <= cfg.data;
      end
      if (wr_en) begin
        tail <= tail + AW'(1);
        fill <= fill + CW'(1);
      end
      if (cmd.start) begin
        remain <= n_eff;
      end
      if (cmd.pop) begin
        head   <= head + AW'(1);
        fill   <= fill - CW'(1);
        remain <= remain - BATCH_W'(1);
      end
    end
  end

  // Output register: load a new beat or drop the taken one
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (cmd.add || cmd.defer || cmd.pop) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      o_status <= full ? ST_FULL : ST_ADDED;
      o_last   <= 1'b1;
    end else if (cmd.defer) begin
      o_status <= ST_WAIT;
      o_last   <= 1'b1;
    end else if (cmd.pop) begin
      o_status <= ST_PLAYED;
      o_last   <= stat.burst_end;
    end
  end

endmodule

FILE: rtl/core/frb_ctrl.sv
// ----------------------------------------------------------------------------
// frb_ctrl: request controller of the frame ring buffer
// Accepts requests when the output is free and sequences play bursts.
// ----------------------------------------------------------------------------
module frb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                kind,
  output logic                in_ready,
  input  frb_pkg::frb_stat_t  stat,
  output frb_pkg::frb_cmd_t   cmd
);
  import frb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_BURST = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE) && stat.slot_free;
  assign accept   = in_valid && in_ready;

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_ADD) begin
            cmd.add = 1'b1;
          end else if (stat.enough) begin
            cmd.start  = 1'b1;
            state_next = S_BURST;
          end else begin
            cmd.defer = 1'b1;
          end
        end
      end
      S_BURST: begin
        // Pop one frame each cycle the output can take it
        cmd.pop = stat.slot_free;
        if (stat.slot_free && stat.burst_end) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
